FILE: src/lwdfp_pkg.sv
// Shared types and codes for the LoRaWAN data frame parser.
package lwdfp_pkg;

   localparam int ByteWidth   = 8;
   localparam int LengthWidth = 9;
   localparam int CountWidth  = 9;

   // Result kinds.
   localparam logic [1:0] KIND_OPTION  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   // Frame status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_SHORT   = 2'd1;
   localparam logic [1:0] STATUS_NODATA  = 2'd2;
   localparam logic [1:0] STATUS_OVERRUN = 2'd3;

   // Frame layout.
   localparam logic [LengthWidth-1:0] MIN_FRAME    = 9'd12;
   localparam logic [LengthWidth-1:0] POS_CONTROL  = 9'd5;
   localparam logic [LengthWidth-1:0] POS_COUNT_LO = 9'd6;
   localparam logic [LengthWidth-1:0] POS_COUNT_HI = 9'd7;
   localparam logic [LengthWidth-1:0] POS_OPTIONS  = 9'd8;
   localparam logic [LengthWidth-1:0] MIC_BYTES    = 9'd4;

   localparam logic [2:0] MTYPE_DATA_FIRST = 3'd2;
   localparam logic [2:0] MTYPE_DATA_LAST  = 3'd5;
   localparam logic [2:0] MTYPE_UNCONF_DN  = 3'd3;
   localparam logic [2:0] MTYPE_CONF_DN    = 3'd5;

   typedef struct packed {
      logic [ByteWidth-1:0]   frame_byte;
      logic                   frame_start;
      logic [LengthWidth-1:0] frame_length;
   } req_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic [ByteWidth-1:0]  data_byte;
      logic [7:0]            mhdr;
      logic [31:0]           device_address;
      logic [7:0]            frame_control;
      logic [15:0]           frame_counter;
      logic [7:0]            port;
      logic [CountWidth-1:0] payload_count;
      logic [31:0]           integrity_code;
      logic                  downlink;
      logic [1:0]            status;
   } rsp_type;

endpackage

FILE: src/lorawan_data_frame_parser_unit.sv
// Top level of the LoRaWAN data frame parser: byte-wise field capture and result output.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | lwdfp_pkg::req_type, one frame byte
//   rsp     | out       | rsp_valid / rsp_ready | lwdfp_pkg::rsp_type, option/payload/summary
//
// One byte is taken per cycle; its result goes from the input register to the result register.
// The rate is set by the input register, which frees up each cycle unless a byte that makes
// a result meets a full result register that is not being drained.
// Synchronous reset clears the frame state and both valid flags.
// Bytes that make no result pass through even while the result register is stalled.
module lorawan_data_frame_parser_unit #(
   parameter int PAYLOAD_MAX = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lwdfp_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lwdfp_pkg::rsp_type rsp_data
);
   import lwdfp_pkg::*;

   localparam logic [CountWidth-1:0] PayloadCap = CountWidth'(PAYLOAD_MAX);

   // Input register.
   logic    in_valid_ff;
   req_type in_data_ff;

   // Frame state.
   logic [LengthWidth-1:0] pos_ff, pos_in;
   logic [LengthWidth-1:0] len_ff, len_in;
   logic [7:0]             header_ff, header_in;
   logic [31:0]            address_ff, address_in;
   logic [7:0]             control_ff, control_in;
   logic [15:0]            counter_ff, counter_in;
   logic [7:0]             port_ff, port_in;
   logic [CountWidth-1:0]  seen_ff, seen_in;
   logic [31:0]            code_ff, code_in;
   logic [1:0]             status_ff, status_in;

   // Result register.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type result;
   logic    has_result;
   logic    advance;

   logic [LengthWidth-1:0] p;
   logic [LengthWidth-1:0] mic_start;
   logic [LengthWidth-1:0] pos_next;
   logic [ByteWidth-1:0]   b;
   logic [3:0]             opt_len;
   logic [LengthWidth:0]   opt_end;
   logic [LengthWidth:0]   need_len;
   logic [2:0]             mtype_in;
   logic [2:0]             mtype_sum;

   always_comb begin
      b = in_data_ff.frame_byte;

      // A start byte clears the frame state before it is looked at.
      if (in_data_ff.frame_start) begin
         pos_in     = '0;
         len_in     = in_data_ff.frame_length;
         header_in  = '0;
         address_in = '0;
         control_in = '0;
         counter_in = '0;
         port_in    = '0;
         seen_in    = '0;
         code_in    = '0;
         status_in  = STATUS_OK;
      end else begin
         pos_in     = pos_ff;
         len_in     = len_ff;
         header_in  = header_ff;
         address_in = address_ff;
         control_in = control_ff;
         counter_in = counter_ff;
         port_in    = port_ff;
         seen_in    = seen_ff;
         code_in    = code_ff;
         status_in  = status_ff;
      end

      p         = pos_in;
      mic_start = len_in - MIC_BYTES;
      opt_len   = control_in[3:0];
      opt_end   = {1'b0, POS_OPTIONS} + {6'd0, opt_len};
      need_len  = {1'b0, MIN_FRAME} + {6'd0, b[3:0]};
      mtype_in  = b[7:5];
      mtype_sum = 3'd0;
      pos_next  = p + 9'd1;
      result    = '0;
      has_result = 1'b0;

      if (p < len_in) begin
         if (p == '0) begin
            if (len_in < MIN_FRAME) begin
               status_in = STATUS_SHORT;
            end else begin
               header_in = b;
               if (mtype_in < MTYPE_DATA_FIRST || mtype_in > MTYPE_DATA_LAST) begin
                  status_in = STATUS_NODATA;
               end
            end
         end else if (status_in == STATUS_OK || status_in == STATUS_OVERRUN) begin
            if (p <= 9'd4) begin
               case (p[2:0])
                  3'd1:    address_in[7:0]   = address_in[7:0] | b;
                  3'd2:    address_in[15:8]  = address_in[15:8] | b;
                  3'd3:    address_in[23:16] = address_in[23:16] | b;
                  default: address_in[31:24] = address_in[31:24] | b;
               endcase
            end else if (p == POS_CONTROL) begin
               control_in = b;
               if ({1'b0, len_in} < need_len) begin
                  status_in = STATUS_OVERRUN;
               end
            end else if (p == POS_COUNT_LO) begin
               counter_in = {8'd0, b};
            end else if (p == POS_COUNT_HI) begin
               counter_in[15:8] = counter_in[15:8] | b;
            end else if (status_in == STATUS_OK) begin
               if ({1'b0, p} < opt_end) begin
                  result.kind      = KIND_OPTION;
                  result.data_byte = b;
                  has_result       = 1'b1;
               end else if (p < mic_start) begin
                  if ({1'b0, p} == opt_end) begin
                     port_in = b;
                  end else if (seen_in < PayloadCap) begin
                     seen_in          = seen_in + 9'd1;
                     result.kind      = KIND_PAYLOAD;
                     result.data_byte = b;
                     has_result       = 1'b1;
                  end
               end
            end
            if (p >= mic_start) begin
               code_in = {b, code_in[31:8]};
            end
         end

         pos_in = pos_next;
         if (pos_next == len_in) begin
            mtype_sum     = header_in[7:5];
            result        = '0;
            result.kind   = KIND_SUMMARY;
            result.status = status_in;
            if (status_in == STATUS_NODATA) begin
               result.mhdr = header_in;
            end else if (status_in != STATUS_SHORT) begin
               result.mhdr           = header_in;
               result.device_address = address_in;
               result.frame_control  = control_in;
               result.frame_counter  = counter_in;
               result.port           = port_in;
               result.payload_count  = seen_in;
               result.integrity_code = code_in;
               result.downlink       = (mtype_sum == MTYPE_UNCONF_DN) ||
                                       (mtype_sum == MTYPE_CONF_DN);
            end
            has_result = 1'b1;
         end
      end
   end

   // The held byte moves on unless its result would overwrite a waiting one.
   assign advance   = in_valid_ff && (!has_result || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         len_ff       <= '0;
         header_ff    <= '0;
         address_ff   <= '0;
         control_ff   <= '0;
         counter_ff   <= '0;
         port_ff      <= '0;
         seen_ff      <= '0;
         code_ff      <= '0;
         status_ff    <= STATUS_OK;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            pos_ff     <= pos_in;
            len_ff     <= len_in;
            header_ff  <= header_in;
            address_ff <= address_in;
            control_ff <= control_in;
            counter_ff <= counter_in;
            port_ff    <= port_in;
            seen_ff    <= seen_in;
            code_ff    <= code_in;
            status_ff  <= status_in;
         end
         if (advance && has_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance && has_result) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= len_ff)
      else $error("byte position beyond frame length");

   a_payload_cap: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= PayloadCap)
      else $error("payload count above cap");

   a_short_status: assert property (@(posedge clock) disable iff (reset)
      status_ff == STATUS_SHORT |-> len_ff < MIN_FRAME)
      else $error("short status on a full-length frame");

   a_held_byte_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("stalled input byte lost");
`endif

endmodule
